// ----- rtl/core/sacd_pkg.sv -----
package sacd_pkg;

	localparam int SETS_DEF = 64;
	localparam int WAYS_DEF = 8;

	localparam int TAG_W   = 32;
	localparam int STAMP_W = 32;
	localparam int CNT_W   = 8;
	localparam int BYTES_W = 25;
	localparam int SLOT_W  = 9;

	localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = 25'd65536;

	// configuration register indexes
	localparam logic [0:0] REG_PF_FIRST    = 1'd0;
	localparam logic [0:0] REG_BLOCK_BYTES = 1'd1;

	// opcodes
	localparam logic [1:0] OP_READ     = 2'd0;
	localparam logic [1:0] OP_PREFETCH = 2'd1;
	localparam logic [1:0] OP_WRITE    = 2'd2;
	localparam logic [1:0] OP_RELEASE  = 2'd3;

	// way status
	localparam logic [1:0] ST_EMPTY = 2'd0;
	localparam logic [1:0] ST_RES   = 2'd1;
	localparam logic [1:0] ST_PRE   = 2'd2;
	localparam logic [1:0] ST_AVAIL = 2'd3;

	// outcomes
	localparam logic [2:0] OC_HIT      = 3'd0;
	localparam logic [2:0] OC_RESERVED = 3'd1;
	localparam logic [2:0] OC_PENDING  = 3'd2;
	localparam logic [2:0] OC_NOSPACE  = 3'd3;
	localparam logic [2:0] OC_STORED   = 3'd4;
	localparam logic [2:0] OC_NOTSTORE = 3'd5;
	localparam logic [2:0] OC_RELEASED = 3'd6;
	localparam logic [2:0] OC_OVERSIZE = 3'd7;

	// eviction kinds
	localparam logic [1:0] EV_NONE = 2'd0;
	localparam logic [1:0] EV_LRU  = 2'd1;
	localparam logic [1:0] EV_PF   = 2'd2;

	typedef struct packed {
		logic [1:0]         opcode;
		logic [31:0]        file_hash;
		logic [31:0]        file_id;
		logic [31:0]        block_number;
		logic [BYTES_W-1:0] request_bytes;
		logic               holds_reservation;
	} req_t;

	typedef struct packed {
		logic [2:0]        outcome;
		logic [SLOT_W-1:0] slot;
		logic              slot_valid;
		logic              hit_was_prefetched;
		logic [1:0]        evicted;
		logic              count_underflow;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic clear;
		logic read;
		logic update;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_done;
	} sts_t;

endpackage

// ----- rtl/core/sacd_req_if.sv -----
interface sacd_req_if;
	logic          valid;
	logic          ready;
	sacd_pkg::req_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/sacd_rsp_if.sv -----
interface sacd_rsp_if;
	logic          valid;
	logic          ready;
	sacd_pkg::rsp_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/set_assoc_block_cache_directory.sv -----
// Tag directory of a set-associative block cache.
// Requests enter on the req channel (valid/ready); one result per request
// leaves on the rsp channel (valid/ready). Configuration registers are
// written through cfg_we/cfg_idx/cfg_data while the block is idle; the user
// must ensure this, the block does not enforce it. An accepted request's set
// is read from the set memory (one wide word holds all ways) into a register,
// then the decide and write-back step registers the result. The next request
// is accepted in the cycle after the result is registered, so each request
// passes the three controller steps, accept, set read, write back, before
// the next is accepted. After reset the set memory is cleared one set per
// cycle, no request is accepted meanwhile; configuration writes still land.
// Config resets: prefetch-first off, block size 65536 bytes.
// When the receiver stalls, the result holds in its output register; one
// more request is accepted and read, then its write-back waits until the
// output register is free.
module set_assoc_block_cache_directory #(
	parameter int SETS = sacd_pkg::SETS_DEF,
	parameter int WAYS = sacd_pkg::WAYS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sacd_req_if.sink                     req,
	sacd_rsp_if.source                   rsp,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_idx,
	input  logic [sacd_pkg::BYTES_W-1:0] cfg_data
);

	sacd_pkg::cmd_t cmd;
	sacd_pkg::sts_t sts;

	sacd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	sacd_datapath #(.SETS(SETS), .WAYS(WAYS)) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.req      (req.payload),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.rsp      (rsp.payload)
	);

endmodule

// ----- rtl/core/sacd_ctrl.sv -----
module sacd_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output sacd_pkg::cmd_t    cmd,
	input  sacd_pkg::sts_t    sts
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_READ  = 2'd2;
	localparam logic [1:0] S_UPD   = 2'd3;

	logic [1:0] state_q;
	logic       out_valid_q;

	// output register frees when taken
	logic out_free;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd.capture = (state_q == S_IDLE) && in_valid;
		cmd.clear   = (state_q == S_CLEAR);
		cmd.read    = (state_q == S_READ);
		cmd.update  = (state_q == S_UPD) && out_free;
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			unique case (state_q)
				S_CLEAR: if (sts.clear_done) state_q <= S_IDLE;
				S_IDLE:  if (in_valid) state_q <= S_READ;
				S_READ:  state_q <= S_UPD;
				S_UPD:   if (out_free) state_q <= S_IDLE;
				default: state_q <= S_CLEAR;
			endcase
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ----- rtl/core/sacd_datapath.sv -----
module sacd_datapath #(
	parameter int SETS = sacd_pkg::SETS_DEF,
	parameter int WAYS = sacd_pkg::WAYS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sacd_pkg::cmd_t               cmd,
	output sacd_pkg::sts_t               sts,
	input  sacd_pkg::req_t               req,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_idx,
	input  logic [sacd_pkg::BYTES_W-1:0] cfg_data,
	output sacd_pkg::rsp_t               rsp
);

	localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int ENT_W = 2 * sacd_pkg::TAG_W + 2 + sacd_pkg::STAMP_W + 1 + sacd_pkg::CNT_W;
	localparam int SLOT_W = sacd_pkg::SLOT_W;

	typedef struct packed {
		logic [sacd_pkg::TAG_W-1:0]   tfile;
		logic [sacd_pkg::TAG_W-1:0]   tblock;
		logic [1:0]                   status;
		logic [sacd_pkg::STAMP_W-1:0] stamp;
		logic                         pf;
		logic [sacd_pkg::CNT_W-1:0]   cnt;
	} ent_t;

	// one wide word per set holds all ways
	logic [WAYS*ENT_W-1:0] mem [SETS];
	logic [WAYS*ENT_W-1:0] rd_q;

	logic                         pf_first_q;
	logic [sacd_pkg::BYTES_W-1:0] block_bytes_q;
	logic [sacd_pkg::STAMP_W-1:0] tick_q;
	logic [SET_W-1:0]             clr_q;
	sacd_pkg::req_t               req_q;
	logic [SET_W-1:0]             set_q;
	sacd_pkg::rsp_t               rsp_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pf_first_q    <= 1'b0;
			block_bytes_q <= sacd_pkg::BLOCK_BYTES_RST;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				sacd_pkg::REG_PF_FIRST:    pf_first_q <= cfg_data[0];
				sacd_pkg::REG_BLOCK_BYTES: block_bytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// set index: 33-bit sum mod SETS, a bit select for power-of-two SETS
	logic [32:0] sum;
	logic [SET_W-1:0] set_idx;
	assign sum = {1'b0, req.file_hash} + {1'b0, req.block_number};
	assign set_idx = SET_W'(sum % 33'(SETS));

	// request capture and clearing counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			tick_q <= '0;
		end else begin
			if (cmd.clear) clr_q <= clr_q + 1'b1;
			if (cmd.update) tick_q <= tick_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_q <= req;
			set_q <= set_idx;
		end
	end

	assign sts.clear_done = cmd.clear && (32'(clr_q) == SETS - 1);

	// per-way decode of the set word
	ent_t ent [WAYS];
	logic [WAYS-1:0] match, is_empty, is_pend, is_avail_m, is_idle, is_idle_pf;
	always_comb begin
		for (int w = 0; w < WAYS; w++) begin
			ent[w] = rd_q[w*ENT_W +: ENT_W];
			match[w] = (ent[w].tfile == req_q.file_id) && (ent[w].tblock == req_q.block_number);
			is_empty[w]   = ent[w].status == sacd_pkg::ST_EMPTY;
			is_pend[w]    = ((ent[w].status == sacd_pkg::ST_RES) ||
				(ent[w].status == sacd_pkg::ST_PRE)) && match[w];
			is_avail_m[w] = (ent[w].status == sacd_pkg::ST_AVAIL) && match[w];
			is_idle[w]    = (ent[w].status == sacd_pkg::ST_AVAIL) && !match[w] &&
				(ent[w].cnt == '0);
			is_idle_pf[w] = is_idle[w] && ent[w].pf && pf_first_q;
		end
	end

	// first way of the scan that stops the search (empty, pending, avail match)
	logic [WAYS-1:0] stop;
	logic            stop_any;
	logic [WAY_W-1:0] stop_w;
	always_comb begin
		stop = is_empty | is_pend | is_avail_m;
		stop_any = 1'b0;
		stop_w = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (stop[w]) begin
				stop_any = 1'b1;
				stop_w = WAY_W'(w);
			end
		end
	end

	// first available match anywhere (for hits and releases)
	logic             av_any;
	logic [WAY_W-1:0] av_w;
	always_comb begin
		av_any = 1'b0;
		av_w = '0;
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (is_avail_m[w]) begin
				av_any = 1'b1;
				av_w = WAY_W'(w);
			end
		end
	end

	// oldest idle way, lowest index on ties; only used when no stop hit
	logic             lru_ok, pfv_ok;
	logic [WAY_W-1:0] lru_w, pfv_w;
	logic [sacd_pkg::STAMP_W-1:0] lru_t, pfv_t;
	always_comb begin
		lru_ok = 1'b0; lru_w = '0; lru_t = '0;
		pfv_ok = 1'b0; pfv_w = '0; pfv_t = '0;
		for (int w = 0; w < WAYS; w++) begin
			if (is_idle[w] && (!lru_ok || ent[w].stamp < lru_t)) begin
				lru_ok = 1'b1; lru_t = ent[w].stamp; lru_w = WAY_W'(w);
			end
			if (is_idle_pf[w] && (!pfv_ok || ent[w].stamp < pfv_t)) begin
				pfv_ok = 1'b1; pfv_t = ent[w].stamp; pfv_w = WAY_W'(w);
			end
		end
	end

	// decision and write-back
	logic [WAYS*ENT_W-1:0] wr_word;
	logic                  wr_en;
	sacd_pkg::rsp_t        r;
	always_comb begin
		logic [WAY_W-1:0] w;
		logic             take;
		logic             oversize;
		logic [1:0]       ev;
		ent_t             e;
		logic [SLOT_W-1:0] slot_n;
		wr_word = rd_q;
		wr_en = 1'b0;
		r = '0;
		take = 1'b0;
		ev = sacd_pkg::EV_NONE;
		w = '0;
		oversize = req_q.request_bytes > block_bytes_q;
		if (stop_any) begin
			w = stop_w;
		end else if (pfv_ok) begin
			w = pfv_w; ev = sacd_pkg::EV_PF;
		end else if (lru_ok) begin
			w = lru_w; ev = sacd_pkg::EV_LRU;
		end
		if (req_q.opcode == sacd_pkg::OP_RELEASE || req_q.opcode == sacd_pkg::OP_READ ||
			req_q.opcode == sacd_pkg::OP_PREFETCH) begin
			if (av_any) w = av_w;
		end
		e = ent[w];
		slot_n = SLOT_W'(32'(set_q) * WAYS + 32'(w));
		if (req_q.opcode == sacd_pkg::OP_RELEASE) begin
			r.outcome = sacd_pkg::OC_RELEASED;
			if (av_any) begin
				r.slot = slot_n; r.slot_valid = 1'b1;
				if (req_q.holds_reservation) begin
					if (e.cnt == '0) r.count_underflow = 1'b1;
					else begin e.cnt = e.cnt - 1'b1; wr_en = 1'b1; end
				end
			end
		end else if (oversize) begin
			r.outcome = sacd_pkg::OC_OVERSIZE;
		end else if (req_q.opcode != sacd_pkg::OP_WRITE) begin
			if (av_any) begin
				r.outcome = sacd_pkg::OC_HIT;
				r.slot = slot_n; r.slot_valid = 1'b1;
				r.hit_was_prefetched = e.pf;
				if (e.cnt != '1) e.cnt = e.cnt + 1'b1;
				if (e.pf) e.pf = (req_q.opcode == sacd_pkg::OP_PREFETCH);
				e.stamp = tick_q;
				wr_en = 1'b1;
			end else if (stop_any && is_pend[w]) begin
				r.outcome = sacd_pkg::OC_PENDING;
				r.slot = slot_n; r.slot_valid = 1'b1;
				if (e.cnt != '1) e.cnt = e.cnt + 1'b1;
				wr_en = 1'b1;
			end else if ((stop_any && is_empty[w]) || pfv_ok || lru_ok) begin
				r.outcome = sacd_pkg::OC_RESERVED;
				r.slot = slot_n; r.slot_valid = 1'b1;
				r.evicted = stop_any ? sacd_pkg::EV_NONE : ev;
				e.tfile = req_q.file_id; e.tblock = req_q.block_number;
				e.status = (req_q.opcode == sacd_pkg::OP_PREFETCH) ?
					sacd_pkg::ST_PRE : sacd_pkg::ST_RES;
				e.pf = (req_q.opcode == sacd_pkg::OP_PREFETCH);
				e.stamp = tick_q;
				if (e.cnt != '1) e.cnt = e.cnt + 1'b1;
				wr_en = 1'b1;
			end else begin
				r.outcome = sacd_pkg::OC_NOSPACE;
			end
		end else begin
			// an available match ends the scan, victims count only without a stop
			take = stop_any ? !is_avail_m[w] : (pfv_ok || lru_ok);
			if (take) begin
				r.outcome = sacd_pkg::OC_STORED;
				r.slot = slot_n; r.slot_valid = 1'b1;
				r.evicted = stop_any ? sacd_pkg::EV_NONE : ev;
				if (stop_any && is_pend[w] && req_q.holds_reservation) begin
					if (e.cnt == '0) r.count_underflow = 1'b1;
					else e.cnt = e.cnt - 1'b1;
				end
				e.tfile = req_q.file_id; e.tblock = req_q.block_number;
				e.status = sacd_pkg::ST_AVAIL;
				e.stamp = tick_q;
				wr_en = 1'b1;
			end else if (stop_any) begin
				r.outcome = sacd_pkg::OC_NOTSTORE;
				r.slot = slot_n; r.slot_valid = 1'b1;
				if (req_q.holds_reservation) begin
					if (e.cnt == '0) r.count_underflow = 1'b1;
					else begin e.cnt = e.cnt - 1'b1; wr_en = 1'b1; end
				end
			end else begin
				r.outcome = sacd_pkg::OC_NOTSTORE;
			end
		end
		wr_word[w*ENT_W +: ENT_W] = e;
	end

	// set memory: registered read, at most one write per request or clear
	always_ff @(posedge clk) begin
		if (cmd.clear) mem[clr_q] <= '0;
		else if (cmd.update && wr_en) mem[set_q] <= wr_word;
		if (cmd.read) rd_q <= mem[set_q];
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.update) rsp_q <= r;
	end
	assign rsp = rsp_q;

endmodule

// ----- tb/sacd_dir_checker.sv -----
`timescale 1ns / 1ps

module sacd_dir_checker #(
	parameter int SETS = sacd_pkg::SETS_DEF,
	parameter int WAYS = sacd_pkg::WAYS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         req_valid,
	input  logic                         req_ready,
	input  sacd_pkg::req_t               req_beat,
	input  logic                         rsp_valid,
	input  logic                         rsp_ready,
	input  sacd_pkg::rsp_t               rsp_beat,
	input  logic                         cfg_we,
	input  logic [0:0]                   cfg_idx,
	input  logic [sacd_pkg::BYTES_W-1:0] cfg_data,
	output int                           fail_count,
	output int                           outstanding
);

	localparam int NSLOT = SETS * WAYS;
	localparam int SLOT_W = sacd_pkg::SLOT_W;

	typedef enum int {PICK_NONE, PICK_EMPTY, PICK_PEND, PICK_AVAIL, PICK_LRU, PICK_PF} pick_e;

	// directory mirror
	logic [31:0]                  dir_file  [NSLOT];
	logic [31:0]                  dir_block [NSLOT];
	logic [1:0]                   dir_status[NSLOT];
	logic [31:0]                  dir_stamp [NSLOT];
	logic                         dir_pf    [NSLOT];
	logic [sacd_pkg::CNT_W-1:0]   dir_users [NSLOT];
	logic [31:0]                  now_tick;
	logic                         pf_first;
	logic [sacd_pkg::BYTES_W-1:0] max_bytes;

	sacd_pkg::rsp_t expected_rsp[$];

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	function automatic int find_avail(int base, logic [31:0] f, logic [31:0] b);
		for (int w = 0; w < WAYS; w++)
			if (dir_status[base+w] == sacd_pkg::ST_AVAIL && dir_file[base+w] == f &&
				dir_block[base+w] == b)
				return w;
		return -1;
	endfunction

	function automatic pick_e scan_set(int base, logic [31:0] f, logic [31:0] b, output int way);
		bit lru_ok, pf_ok;
		int lru_w, pf_w, s;
		logic [31:0] lru_t, pf_t;
		bit m;
		lru_ok = 1'b0; pf_ok = 1'b0; lru_w = 0; pf_w = 0; lru_t = '0; pf_t = '0;
		for (int w = 0; w < WAYS; w++) begin
			s = base + w;
			m = dir_file[s] == f && dir_block[s] == b;
			if (dir_status[s] == sacd_pkg::ST_EMPTY) begin
				way = w; return PICK_EMPTY;
			end
			if ((dir_status[s] == sacd_pkg::ST_RES || dir_status[s] == sacd_pkg::ST_PRE) &&
				m) begin
				way = w; return PICK_PEND;
			end
			if (dir_status[s] == sacd_pkg::ST_AVAIL) begin
				if (m) begin
					way = w; return PICK_AVAIL;
				end
				if (dir_users[s] == '0) begin
					if (!lru_ok || dir_stamp[s] < lru_t) begin
						lru_ok = 1'b1; lru_t = dir_stamp[s]; lru_w = w;
					end
					if (pf_first && dir_pf[s] && (!pf_ok || dir_stamp[s] < pf_t)) begin
						pf_ok = 1'b1; pf_t = dir_stamp[s]; pf_w = w;
					end
				end
			end
		end
		if (pf_first && pf_ok) begin
			way = pf_w; return PICK_PF;
		end
		if (lru_ok) begin
			way = lru_w; return PICK_LRU;
		end
		way = 0;
		return PICK_NONE;
	endfunction

	function automatic logic give_back(int s);
		if (dir_users[s] == '0) return 1'b1;
		dir_users[s]--;
		return 1'b0;
	endfunction

	function automatic logic [1:0] evict_kind(pick_e k);
		return k == PICK_LRU ? sacd_pkg::EV_LRU :
			(k == PICK_PF ? sacd_pkg::EV_PF : sacd_pkg::EV_NONE);
	endfunction

	// compute the result of one request and update the mirror
	function automatic sacd_pkg::rsp_t lookup_directory(sacd_pkg::req_t r);
		sacd_pkg::rsp_t o;
		int base, w, s, hw;
		pick_e k;
		logic [31:0] stamp_now;
		o = '0;
		base = int'((64'(r.file_hash) + 64'(r.block_number)) % SETS) * WAYS;
		stamp_now = now_tick;
		now_tick = now_tick + 32'd1;
		if (r.opcode == sacd_pkg::OP_RELEASE) begin
			o.outcome = sacd_pkg::OC_RELEASED;
			hw = find_avail(base, r.file_id, r.block_number);
			if (hw >= 0) begin
				s = base + hw;
				o.slot = s[SLOT_W-1:0]; o.slot_valid = 1'b1;
				if (r.holds_reservation) o.count_underflow = give_back(s);
			end
			return o;
		end
		if (r.request_bytes > max_bytes) begin
			o.outcome = sacd_pkg::OC_OVERSIZE;
			return o;
		end
		if (r.opcode == sacd_pkg::OP_READ || r.opcode == sacd_pkg::OP_PREFETCH) begin
			hw = find_avail(base, r.file_id, r.block_number);
			if (hw >= 0) begin
				s = base + hw;
				if (dir_users[s] != 8'hff) dir_users[s]++;
				o.outcome = sacd_pkg::OC_HIT; o.slot = s[SLOT_W-1:0]; o.slot_valid = 1'b1;
				o.hit_was_prefetched = dir_pf[s];
				if (dir_pf[s]) dir_pf[s] = r.opcode == sacd_pkg::OP_PREFETCH;
				dir_stamp[s] = stamp_now;
				return o;
			end
			k = scan_set(base, r.file_id, r.block_number, w);
			s = base + w;
			if (k == PICK_PEND) begin
				if (dir_users[s] != 8'hff) dir_users[s]++;
				o.outcome = sacd_pkg::OC_PENDING; o.slot = s[SLOT_W-1:0];
				o.slot_valid = 1'b1;
			end else if (k == PICK_EMPTY || k == PICK_LRU || k == PICK_PF) begin
				dir_file[s] = r.file_id; dir_block[s] = r.block_number;
				dir_status[s] = r.opcode == sacd_pkg::OP_PREFETCH ?
					sacd_pkg::ST_PRE : sacd_pkg::ST_RES;
				dir_pf[s] = r.opcode == sacd_pkg::OP_PREFETCH;
				dir_stamp[s] = stamp_now;
				if (dir_users[s] != 8'hff) dir_users[s]++;
				o.outcome = sacd_pkg::OC_RESERVED; o.slot = s[SLOT_W-1:0];
				o.slot_valid = 1'b1;
				o.evicted = evict_kind(k);
			end else begin
				o.outcome = sacd_pkg::OC_NOSPACE;
			end
			return o;
		end
		// write fill
		k = scan_set(base, r.file_id, r.block_number, w);
		s = base + w;
		if (k == PICK_AVAIL) begin
			o.outcome = sacd_pkg::OC_NOTSTORE; o.slot = s[SLOT_W-1:0]; o.slot_valid = 1'b1;
			if (r.holds_reservation) o.count_underflow = give_back(s);
		end else if (k == PICK_NONE) begin
			o.outcome = sacd_pkg::OC_NOTSTORE;
		end else begin
			dir_file[s] = r.file_id; dir_block[s] = r.block_number;
			dir_status[s] = sacd_pkg::ST_AVAIL;
			dir_stamp[s] = stamp_now;
			o.outcome = sacd_pkg::OC_STORED; o.slot = s[SLOT_W-1:0]; o.slot_valid = 1'b1;
			o.evicted = evict_kind(k);
			if (k == PICK_PEND && r.holds_reservation) o.count_underflow = give_back(s);
		end
		return o;
	endfunction

	// watch beats, predict and compare
	always @(posedge clk or negedge arst_n) begin
		sacd_pkg::rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				dir_file[i] = '0; dir_block[i] = '0; dir_status[i] = sacd_pkg::ST_EMPTY;
				dir_stamp[i] = '0; dir_pf[i] = 1'b0; dir_users[i] = '0;
			end
			now_tick = '0;
			pf_first = 1'b0;
			max_bytes = sacd_pkg::BLOCK_BYTES_RST;
			expected_rsp.delete();
			fail_count = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_idx == sacd_pkg::REG_PF_FIRST) pf_first = cfg_data[0];
				else max_bytes = cfg_data;
			end
			if (req_valid && req_ready)
				expected_rsp.push_back(lookup_directory(req_beat));
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					$display("unexpected result beat at %0t", $realtime);
					fail_count++;
				end else begin
					want = expected_rsp.pop_front();
					if (rsp_beat.outcome !== want.outcome)
						report("outcome", 32'(rsp_beat.outcome), 32'(want.outcome));
					if (rsp_beat.slot !== want.slot)
						report("slot", 32'(rsp_beat.slot), 32'(want.slot));
					if (rsp_beat.slot_valid !== want.slot_valid)
						report("slot_valid", 32'(rsp_beat.slot_valid), 32'(want.slot_valid));
					if (rsp_beat.hit_was_prefetched !== want.hit_was_prefetched)
						report("hit_was_prefetched", 32'(rsp_beat.hit_was_prefetched),
							32'(want.hit_was_prefetched));
					if (rsp_beat.evicted !== want.evicted)
						report("evicted", 32'(rsp_beat.evicted), 32'(want.evicted));
					if (rsp_beat.count_underflow !== want.count_underflow)
						report("count_underflow", 32'(rsp_beat.count_underflow),
							32'(want.count_underflow));
				end
			end
			outstanding = expected_rsp.size();
		end
	end

endmodule

// ----- tb/set_assoc_block_cache_directory_test.sv -----
`timescale 1ns / 1ps

module set_assoc_block_cache_directory_test;

	localparam int SETS = sacd_pkg::SETS_DEF;
	localparam int WAYS = sacd_pkg::WAYS_DEF;
	localparam int STALL_LIMIT = 20000;

	logic                         clk;
	logic                         arst_n;
	logic                         cfg_we;
	logic [0:0]                   cfg_idx;
	logic [sacd_pkg::BYTES_W-1:0] cfg_data;
	int                           fail_count;
	int                           outstanding;
	int                           idle_cycles = 0;

	sacd_req_if req();
	sacd_rsp_if rsp();

	set_assoc_block_cache_directory #(.SETS(SETS), .WAYS(WAYS)) dut (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data)
	);

	sacd_dir_checker #(.SETS(SETS), .WAYS(WAYS)) checker_i (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req.valid), .req_ready(req.ready), .req_beat(req.payload),
		.rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_beat(rsp.payload),
		.cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_data(cfg_data),
		.fail_count(fail_count), .outstanding(outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver stall pattern: phases of steady ready, random and heavy stall
	initial begin
		int mode, len;
		rsp.ready = 1'b0;
		forever begin
			mode = $urandom_range(0, 2);
			len = $urandom_range(5, 60);
			repeat (len) begin
				@(posedge clk);
				case (mode)
					0: rsp.ready <= 1'b1;
					1: rsp.ready <= 1'($urandom_range(0, 1));
					default: begin
						rsp.ready <= ($urandom_range(0, 5) == 0);
					end
				endcase
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// small pool of hot tags so that hits, pending matches and evictions occur
	function automatic sacd_pkg::req_t make_request(int hot_sets);
		sacd_pkg::req_t r;
		r.opcode = 2'($urandom_range(0, 3));
		if ($urandom_range(0, 9) == 0) begin
			r.file_hash = $urandom();
			r.file_id = $urandom();
			r.block_number = $urandom();
		end else begin
			r.file_hash = 32'($urandom_range(0, 3)) * SETS;
			r.file_id = $urandom_range(0, 2);
			r.block_number = 32'($urandom_range(0, 11)) * SETS
				+ 32'($urandom_range(0, hot_sets - 1));
		end
		case ($urandom_range(0, 9))
			0: r.request_bytes = '1;
			1: r.request_bytes = sacd_pkg::BYTES_W'($urandom());
			2: r.request_bytes = '0;
			default: r.request_bytes = sacd_pkg::BYTES_W'($urandom_range(0, 70000));
		endcase
		r.holds_reservation = $urandom_range(0, 3) != 0;
		return r;
	endfunction

	task automatic send(input sacd_pkg::req_t r);
		req.valid <= 1'b1;
		req.payload <= r;
		do @(posedge clk); while (!req.ready);
	endtask

	task automatic gap();
		req.valid <= 1'b0;
		repeat ($urandom_range(1, 6)) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [sacd_pkg::BYTES_W-1:0] val);
		cfg_we <= 1'b1; cfg_idx <= idx; cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		req.valid <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic random_phase(input int count, input int hot_sets);
		int left, burst;
		left = count;
		while (left > 0) begin
			burst = $urandom_range(1, 20);
			while (burst > 0 && left > 0) begin
				send(make_request(hot_sets));
				burst--; left--;
			end
			if ($urandom_range(0, 2) != 0) gap();
		end
	endtask

	initial begin
		sacd_pkg::req_t r;
		arst_n = 1'b0;
		cfg_we = 1'b0; cfg_idx = sacd_pkg::REG_PF_FIRST; cfg_data = '0;
		req.valid = 1'b0; req.payload = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every opcode, size limits, fill of one set
		write_reg(sacd_pkg::REG_BLOCK_BYTES, 25'd100);
		r = '0;
		r.opcode = sacd_pkg::OP_READ; r.request_bytes = 25'd100; send(r);
		r.request_bytes = 25'd101; send(r);
		r.opcode = sacd_pkg::OP_RELEASE; r.request_bytes = '1; r.holds_reservation = 1'b1;
		send(r);
		r.opcode = sacd_pkg::OP_WRITE; r.request_bytes = '0; send(r);
		r.opcode = sacd_pkg::OP_PREFETCH; send(r);
		r.opcode = sacd_pkg::OP_RELEASE; send(r); send(r); send(r);
		r.opcode = sacd_pkg::OP_WRITE; send(r);
		r.file_hash = '1; r.file_id = '1; r.block_number = '1;
		r.opcode = sacd_pkg::OP_PREFETCH; send(r);
		r.opcode = sacd_pkg::OP_WRITE; send(r);
		r.opcode = sacd_pkg::OP_READ; send(r);
		r.holds_reservation = 1'b0;
		for (int i = 0; i < WAYS + 2; i++) begin
			r.file_hash = '0; r.file_id = 32'(i); r.block_number = 32'd5;
			r.opcode = sacd_pkg::OP_PREFETCH; send(r);
		end
		drain();
		write_reg(sacd_pkg::REG_BLOCK_BYTES, '1);
		write_reg(sacd_pkg::REG_PF_FIRST, 25'd1);
		for (int i = 0; i < WAYS + 2; i++) begin
			r.file_id = 32'(i); r.opcode = sacd_pkg::OP_WRITE; send(r);
		end
		r.file_id = 32'd100; r.opcode = sacd_pkg::OP_READ; send(r);
		drain();

		// random phases across settings
		write_reg(sacd_pkg::REG_BLOCK_BYTES, 25'd65536);
		random_phase(400, 2);
		drain();
		write_reg(sacd_pkg::REG_PF_FIRST, 25'd0);
		write_reg(sacd_pkg::REG_BLOCK_BYTES, 25'd1);
		random_phase(200, 4);
		drain();
		write_reg(sacd_pkg::REG_BLOCK_BYTES, 25'd16777216);
		random_phase(400, 1);
		drain();
		write_reg(sacd_pkg::REG_PF_FIRST, 25'd1);
		write_reg(sacd_pkg::REG_BLOCK_BYTES, 25'd50000);
		random_phase(400, 3);

		// final drain
		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/sacd_pkg.sv
rtl/core/sacd_req_if.sv
rtl/core/sacd_rsp_if.sv
rtl/core/sacd_ctrl.sv
rtl/core/sacd_datapath.sv
rtl/core/set_assoc_block_cache_directory.sv
tb/sacd_dir_checker.sv
tb/set_assoc_block_cache_directory_test.sv
